// File: rtl/rgb2hsl_pkg.sv
// ============================================================================
// rgb2hsl_pkg
// Shared widths, constants and the divider lane type of the RGB to HSL block.
// ============================================================================
package rgb2hsl_pkg;

    // Default number of fraction bits of the results
    localparam int FRAC_BITS_DEF = 16;

    // Pixel component width
    localparam int PIX_W = 8;

    // max + min of two components
    localparam int SUM_W = PIX_W + 1;

    // Divider operand width: covers the hue divisor 6 * 255 = 1530
    localparam int DEN_W = 11;

    // Lightness divisor and the saturation split point
    localparam logic [DEN_W-1:0] LIGHT_DEN = DEN_W'(510);
    localparam logic [SUM_W-1:0] SUM_FULL  = SUM_W'(510);
    localparam logic [SUM_W-1:0] SUM_HALF  = SUM_W'(255);

    // One divider lane: running remainder (below den after the integer step) and divisor
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
    } div_lane_t;

endpackage

// File: rtl/rgb_to_hsl.sv
// ============================================================================
// rgb_to_hsl
// Pipelined RGB to HSL converter, one pixel per clock while not stalled.
// ============================================================================
// Usage:
//   The pixel channel (pixel_valid / pixel_ready) takes one 8-bit red, green,
//   blue request per clock while pixel_ready is high. The hsl channel
//   (hsl_valid / hsl_ready) returns hue, saturation and lightness as unsigned
//   fractions scaled by 2^FRAC_BITS, rounded to nearest, each FRAC_BITS+1
//   bits wide. An accepted pixel passes two operand stages, FRAC_BITS+2
//   divider stages and one output register before hsl_valid. Throughput is
//   one pixel per cycle while the pipeline is not stalled; the divider chain,
//   one quotient bit per stage across three lanes, sets the depth.
//   The pipeline advances as a whole. When the receiver stalls, the output
//   register holds its request and a one-entry skid buffer catches the next
//   one leaving the pipeline; only once the skid is full does pixel_ready
//   drop, and it rises again the cycle after the receiver drains the output.
//   Reset clears all valid bits, the output valid flag and the skid flag; the
//   block takes a pixel in the first cycle after reset is released.
// ============================================================================
module rgb_to_hsl
#(
    parameter int FRAC_BITS = rgb2hsl_pkg::FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  logic [rgb2hsl_pkg::PIX_W-1:0] red,
    input  logic [rgb2hsl_pkg::PIX_W-1:0] green,
    input  logic [rgb2hsl_pkg::PIX_W-1:0] blue,
    output logic                          hsl_valid,
    input  logic                          hsl_ready,
    output logic [FRAC_BITS:0]            hue,
    output logic [FRAC_BITS:0]            saturation,
    output logic [FRAC_BITS:0]            lightness
);

    // quotient before rounding carries one extra bit below the LSB
    localparam int QW        = FRAC_BITS + 2;
    localparam int OW        = FRAC_BITS + 1;
    localparam int NSTEP     = FRAC_BITS + 2;
    localparam int NST       = NSTEP + 2;
    localparam int NUM_LANES = 3;
    localparam int LANE_HUE  = 0;
    localparam int LANE_SAT  = 1;
    localparam int LANE_LIT  = 2;
    localparam logic [OW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    logic                   stage_en;
    logic [NST-1:0]         valid_reg;
    logic [NST-1:0]         valid_next;

    rgb2hsl_pkg::div_lane_t lane_pipe [0:NSTEP][0:NUM_LANES-1];
    logic [QW-1:0]          quo_pipe  [0:NSTEP][0:NUM_LANES-1];

    // Advance the whole pipeline unless the skid buffer holds a request
    logic                   skid_full_reg;
    logic                   skid_full_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    assign stage_en    = !skid_full_reg;
    assign pixel_ready = stage_en;
    assign valid_next  = {valid_reg[NST-2:0], pixel_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (stage_en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Operand stages
    rgb2hsl_front u_front
    (
        .clk        (clk),
        .en         (stage_en),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hue_lane   (lane_pipe[0][LANE_HUE]),
        .sat_lane   (lane_pipe[0][LANE_SAT]),
        .light_lane (lane_pipe[0][LANE_LIT])
    );

    // Divider chain: first stage yields the integer bit, the rest the fraction
    genvar s, k;
    generate
        for (k = 0; k < NUM_LANES; k++)
        begin : g_quo_init
            assign quo_pipe[0][k] = '0;
        end
        for (s = 0; s < NSTEP; s++)
        begin : g_step
            for (k = 0; k < NUM_LANES; k++)
            begin : g_lane
                rgb2hsl_div_step
                #(
                    .QW     (QW),
                    .DOUBLE (s != 0)
                )
                u_step
                (
                    .clk      (clk),
                    .en       (stage_en),
                    .src_lane (lane_pipe[s][k]),
                    .src_quo  (quo_pipe[s][k]),
                    .lane     (lane_pipe[s+1][k]),
                    .quo      (quo_pipe[s+1][k])
                );
            end
        end
    endgenerate

    // Round to nearest: q = (2n/d scaled + 1) / 2, exact ties go up
    logic [QW-1:0] hue_rnd;
    logic [QW-1:0] sat_rnd;
    logic [QW-1:0] lit_rnd;

    assign hue_rnd = quo_pipe[NSTEP][LANE_HUE] + QW'(1);
    assign sat_rnd = quo_pipe[NSTEP][LANE_SAT] + QW'(1);
    assign lit_rnd = quo_pipe[NSTEP][LANE_LIT] + QW'(1);

    // Output register and skid buffer
    logic          push;
    logic          take;
    logic          load_out;
    logic          load_skid;
    logic          from_skid;
    logic [OW-1:0] hue_reg;
    logic [OW-1:0] sat_reg;
    logic [OW-1:0] lit_reg;
    logic [OW-1:0] skid_hue_reg;
    logic [OW-1:0] skid_sat_reg;
    logic [OW-1:0] skid_lit_reg;

    assign push = stage_en && valid_reg[NST-1];
    assign take = !out_valid_reg || hsl_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        load_out       = 1'b0;
        load_skid      = 1'b0;
        from_skid      = 1'b0;
        if (take)
        begin
            if (skid_full_reg)
            begin
                // drain the skid first; the pipeline is frozen this cycle
                out_valid_next = 1'b1;
                skid_full_next = 1'b0;
                load_out       = 1'b1;
                from_skid      = 1'b1;
            end
            else
            begin
                out_valid_next = push;
                load_out       = push;
            end
        end
        else if (push)
        begin
            // output held: park the next request
            skid_full_next = 1'b1;
            load_skid      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            hue_reg <= from_skid ? skid_hue_reg : hue_rnd[QW-1:1];
            sat_reg <= from_skid ? skid_sat_reg : sat_rnd[QW-1:1];
            lit_reg <= from_skid ? skid_lit_reg : lit_rnd[QW-1:1];
        end
        if (load_skid)
        begin
            skid_hue_reg <= hue_rnd[QW-1:1];
            skid_sat_reg <= sat_rnd[QW-1:1];
            skid_lit_reg <= lit_rnd[QW-1:1];
        end
    end

    assign hsl_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = lit_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid buffer full while output register empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && !hsl_ready))
        else $error("skid buffer filled without a stalled output");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hue_reg <= ONE_Q) && (sat_reg <= ONE_Q)
                          && (lit_reg <= ONE_Q))
        else $error("result above one full unit");

    a_black_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && lit_reg == '0) |-> (hue_reg == '0) && (sat_reg == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

// File: rtl/rgb2hsl_front.sv
// ============================================================================
// rgb2hsl_front
// Two register stages: find max/min, then build the three division operands.
// ============================================================================
module rgb2hsl_front
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [rgb2hsl_pkg::PIX_W-1:0] red,
    input  logic [rgb2hsl_pkg::PIX_W-1:0] green,
    input  logic [rgb2hsl_pkg::PIX_W-1:0] blue,
    output rgb2hsl_pkg::div_lane_t        hue_lane,
    output rgb2hsl_pkg::div_lane_t        sat_lane,
    output rgb2hsl_pkg::div_lane_t        light_lane
);

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    // Stage A
    logic [rgb2hsl_pkg::SUM_W-1:0] sum_reg;
    logic [rgb2hsl_pkg::SUM_W-1:0] sum_next;
    logic [rgb2hsl_pkg::PIX_W-1:0] delta_reg;
    logic [rgb2hsl_pkg::PIX_W-1:0] delta_next;
    logic [rgb2hsl_pkg::SUM_W-1:0] diff_reg;
    logic [rgb2hsl_pkg::SUM_W-1:0] diff_next;
    max_sel_t                      sel_reg;
    max_sel_t                      sel_next;

    // Stage B
    rgb2hsl_pkg::div_lane_t hue_lane_reg;
    rgb2hsl_pkg::div_lane_t hue_lane_next;
    rgb2hsl_pkg::div_lane_t sat_lane_reg;
    rgb2hsl_pkg::div_lane_t sat_lane_next;
    rgb2hsl_pkg::div_lane_t light_lane_reg;
    rgb2hsl_pkg::div_lane_t light_lane_next;

    logic [rgb2hsl_pkg::PIX_W-1:0] mx;
    logic [rgb2hsl_pkg::PIX_W-1:0] mn;

    always_comb
    begin
        // ties go to red, then green
        if (red >= green && red >= blue)
        begin
            sel_next  = MAX_RED;
            mx        = red;
            diff_next = {1'b0, green} - {1'b0, blue};
        end
        else if (green >= blue)
        begin
            sel_next  = MAX_GREEN;
            mx        = green;
            diff_next = {1'b0, blue} - {1'b0, red};
        end
        else
        begin
            sel_next  = MAX_BLUE;
            mx        = blue;
            diff_next = {1'b0, red} - {1'b0, green};
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        sum_next   = {1'b0, mx} + {1'b0, mn};
        delta_next = mx - mn;
    end

    logic [rgb2hsl_pkg::DEN_W-1:0] d1;
    logic [rgb2hsl_pkg::DEN_W-1:0] d2;
    logic [rgb2hsl_pkg::DEN_W-1:0] d4;
    logic [rgb2hsl_pkg::DEN_W-1:0] d6;
    logic [rgb2hsl_pkg::DEN_W-1:0] base;
    logic [rgb2hsl_pkg::DEN_W-1:0] num;
    logic [rgb2hsl_pkg::SUM_W-1:0] sat_den;
    logic                          grey;

    always_comb
    begin
        d1 = rgb2hsl_pkg::DEN_W'(delta_reg);
        d2 = d1 << 1;
        d4 = d1 << 2;
        d6 = d2 + d4;
        unique case (sel_reg)
            MAX_RED:   base = diff_reg[rgb2hsl_pkg::SUM_W-1] ? d6 : '0;
            MAX_GREEN: base = d2;
            MAX_BLUE:  base = d4;
            default:   base = '0;
        endcase
        // sign-extend the difference; the sum is never negative
        num  = base + {{(rgb2hsl_pkg::DEN_W-rgb2hsl_pkg::SUM_W)
                        {diff_reg[rgb2hsl_pkg::SUM_W-1]}}, diff_reg};
        grey = (delta_reg == '0);

        if (sum_reg < rgb2hsl_pkg::SUM_HALF)
        begin
            sat_den = sum_reg;
        end
        else
        begin
            sat_den = rgb2hsl_pkg::SUM_FULL - sum_reg;
        end

        // grey pixel: divide zero by one so hue and saturation come out zero
        if (grey)
        begin
            hue_lane_next.rem = '0;
            hue_lane_next.den = rgb2hsl_pkg::DEN_W'(1);
            sat_lane_next.rem = '0;
            sat_lane_next.den = rgb2hsl_pkg::DEN_W'(1);
        end
        else
        begin
            hue_lane_next.rem = num;
            hue_lane_next.den = d6;
            sat_lane_next.rem = d1;
            sat_lane_next.den = rgb2hsl_pkg::DEN_W'(sat_den);
        end
        light_lane_next.rem = rgb2hsl_pkg::DEN_W'(sum_reg);
        light_lane_next.den = rgb2hsl_pkg::LIGHT_DEN;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg        <= sum_next;
            delta_reg      <= delta_next;
            diff_reg       <= diff_next;
            sel_reg        <= sel_next;
            hue_lane_reg   <= hue_lane_next;
            sat_lane_reg   <= sat_lane_next;
            light_lane_reg <= light_lane_next;
        end
    end

    assign hue_lane   = hue_lane_reg;
    assign sat_lane   = sat_lane_reg;
    assign light_lane = light_lane_reg;

endmodule

// File: rtl/rgb2hsl_div_step.sv
// ============================================================================
// rgb2hsl_div_step
// One registered restoring-division step: one quotient bit per stage.
// ============================================================================
module rgb2hsl_div_step
#(
    parameter int QW     = rgb2hsl_pkg::FRAC_BITS_DEF + 2,
    parameter bit DOUBLE = 1'b1
)
(
    input  logic                   clk,
    input  logic                   en,
    input  rgb2hsl_pkg::div_lane_t src_lane,
    input  logic [QW-1:0]          src_quo,
    output rgb2hsl_pkg::div_lane_t lane,
    output logic [QW-1:0]          quo
);

    rgb2hsl_pkg::div_lane_t        lane_reg;
    rgb2hsl_pkg::div_lane_t        lane_next;
    logic [QW-1:0]                 quo_reg;
    logic [QW-1:0]                 quo_next;
    logic [rgb2hsl_pkg::DEN_W:0]   trial;
    logic [rgb2hsl_pkg::DEN_W:0]   diff;
    logic                          ge;

    always_comb
    begin
        // the integer step compares the numerator itself, later steps shift
        if (DOUBLE)
        begin
            trial = {src_lane.rem, 1'b0};
        end
        else
        begin
            trial = {1'b0, src_lane.rem};
        end
        diff          = trial - {1'b0, src_lane.den};
        ge            = (trial >= {1'b0, src_lane.den});
        lane_next.den = src_lane.den;
        lane_next.rem = ge ? diff[rgb2hsl_pkg::DEN_W-1:0]
                           : trial[rgb2hsl_pkg::DEN_W-1:0];
        quo_next      = {src_quo[QW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            quo_reg  <= quo_next;
        end
    end

    assign lane = lane_reg;
    assign quo  = quo_reg;

endmodule
